FILE: rtl/core/epoch_seconds_to_calendar_assert.svh
// Assertion macros for the calendar converter checks.
// Each expects i_clk and i_rst_n in scope.
`ifndef EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH

// Same-cycle implication.
`define ECAL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ecal check failed");

// Next-cycle implication.
`define ECAL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ecal check failed");

`endif

FILE: rtl/core/ecal_pkg.sv
package ecal_pkg;

    localparam int PcW = 4;
    typedef logic [PcW-1:0] t_pc;

    // datapath operations
    localparam logic [3:0] OP_NOP    = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_DAY_Q  = 4'd2;
    localparam logic [3:0] OP_DAY_R  = 4'd3;
    localparam logic [3:0] OP_HOUR_Q = 4'd4;
    localparam logic [3:0] OP_HOUR_R = 4'd5;
    localparam logic [3:0] OP_MIN_Q  = 4'd6;
    localparam logic [3:0] OP_MIN_R  = 4'd7;
    localparam logic [3:0] OP_YEAR   = 4'd8;
    localparam logic [3:0] OP_MONTH  = 4'd9;
    localparam logic [3:0] OP_EMIT   = 4'd10;

    // step exit conditions
    localparam logic [1:0] JMP_GO   = 2'd0;
    localparam logic [1:0] JMP_IN   = 2'd1;
    localparam logic [1:0] JMP_DONE = 2'd2;
    localparam logic [1:0] JMP_OUT  = 2'd3;

    // program addresses
    localparam t_pc PC_WAIT   = 4'd0;
    localparam t_pc PC_DAY_Q  = 4'd1;
    localparam t_pc PC_DAY_R  = 4'd2;
    localparam t_pc PC_HOUR_Q = 4'd3;
    localparam t_pc PC_HOUR_R = 4'd4;
    localparam t_pc PC_MIN_Q  = 4'd5;
    localparam t_pc PC_MIN_R  = 4'd6;
    localparam t_pc PC_YEAR   = 4'd7;
    localparam t_pc PC_MONTH  = 4'd8;
    localparam t_pc PC_EMIT   = 4'd9;

    localparam int          SecsPerDayInt = 86400;
    // seconds per day in units of 128 s
    localparam logic [9:0]  DayUnit     = 10'(SecsPerDayInt / 128);
    localparam logic [16:0] SecsPerHour = 17'd3600;
    localparam logic [11:0] SecsPerMin  = 12'd60;

    // reciprocals, exact over each dividend range
    localparam logic [25:0] DayMul    = 26'd50903317; // ceil(2^35 / 675)
    localparam int          DayShift  = 35;
    localparam logic [16:0] WeekMul   = 17'd74899;    // ceil(2^19 / 7)
    localparam int          WeekShift = 19;
    localparam logic [17:0] HourMul   = 18'd149131;   // ceil(2^29 / 3600)
    localparam int          HourShift = 29;
    localparam logic [12:0] MinMul    = 13'd4370;     // ceil(2^18 / 60)
    localparam int          MinShift  = 18;

    localparam int          BaseYearInt = 1970;
    localparam logic [11:0] BaseYear    = 12'(BaseYearInt);
    localparam logic [1:0]  BaseMod4    = 2'(BaseYearInt % 4);
    localparam logic [6:0]  BaseMod100  = 7'(BaseYearInt % 100);
    localparam logic [8:0]  BaseMod400  = 9'(BaseYearInt % 400);

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] jmp;
        t_pc        tgt;
    } t_cw;

    typedef struct packed {
        t_cw  cw;
        logic go;
    } t_ctl;

    typedef struct packed {
        logic loop_done;
        logic out_free;
    } t_dp_stat;

    function automatic t_cw ucode(input t_pc pc);
        t_cw cw;
        unique case (pc)
            PC_WAIT:   cw = '{op: OP_LOAD,   jmp: JMP_IN,   tgt: PC_DAY_Q};
            PC_DAY_Q:  cw = '{op: OP_DAY_Q,  jmp: JMP_GO,   tgt: PC_DAY_R};
            PC_DAY_R:  cw = '{op: OP_DAY_R,  jmp: JMP_GO,   tgt: PC_HOUR_Q};
            PC_HOUR_Q: cw = '{op: OP_HOUR_Q, jmp: JMP_GO,   tgt: PC_HOUR_R};
            PC_HOUR_R: cw = '{op: OP_HOUR_R, jmp: JMP_GO,   tgt: PC_MIN_Q};
            PC_MIN_Q:  cw = '{op: OP_MIN_Q,  jmp: JMP_GO,   tgt: PC_MIN_R};
            PC_MIN_R:  cw = '{op: OP_MIN_R,  jmp: JMP_GO,   tgt: PC_YEAR};
            PC_YEAR:   cw = '{op: OP_YEAR,   jmp: JMP_DONE, tgt: PC_MONTH};
            PC_MONTH:  cw = '{op: OP_MONTH,  jmp: JMP_DONE, tgt: PC_EMIT};
            PC_EMIT:   cw = '{op: OP_EMIT,   jmp: JMP_OUT,  tgt: PC_WAIT};
            default:   cw = '{op: OP_NOP,    jmp: JMP_GO,   tgt: PC_WAIT};
        endcase
        return cw;
    endfunction

    // month index from 0
    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        case (mon) inside
            4'd1:                   len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

FILE: rtl/core/ecal_ifs.sv
interface ecal_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] seconds_count;

    modport source (output valid, output seconds_count, input ready);
    modport sink   (input valid, input seconds_count, output ready);
endinterface

interface ecal_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] cal_year;
    logic [3:0]  cal_month;
    logic [4:0]  cal_day;
    logic [4:0]  cal_hour;
    logic [5:0]  cal_minute;
    logic [5:0]  cal_second;
    logic [2:0]  weekday;

    modport source (output valid, output cal_year, output cal_month, output cal_day,
                    output cal_hour, output cal_minute, output cal_second,
                    output weekday, input ready);
    modport sink   (input valid, input cal_year, input cal_month, input cal_day,
                    input cal_hour, input cal_minute, input cal_second,
                    input weekday, output ready);
endinterface

FILE: rtl/core/ecal_seq.sv
module ecal_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  ecal_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output ecal_pkg::t_ctl    o_ctl
);
    import ecal_pkg::*;

    t_pc        r_pc;
    t_pc        n_pc;
    t_cw        cw;
    logic       go;

    assign cw = ucode(r_pc);

    always_comb begin
        unique case (cw.jmp)
            JMP_GO:   go = 1'b1;
            JMP_IN:   go = i_in_valid;
            JMP_DONE: go = i_stat.loop_done;
            JMP_OUT:  go = i_stat.out_free;
            default:  go = 1'b1;
        endcase
    end

    assign n_pc = go ? cw.tgt : r_pc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_in_ready = (cw.jmp == JMP_IN);
    assign o_ctl      = '{cw: cw, go: go};

endmodule

FILE: rtl/core/ecal_dp.sv
module ecal_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ecal_pkg::t_ctl     i_ctl,
    input  logic [31:0]        i_seconds_count,
    input  logic               i_out_ready,
    output ecal_pkg::t_dp_stat o_stat,
    output logic               o_out_valid,
    output logic [11:0]        o_cal_year,
    output logic [3:0]         o_cal_month,
    output logic [4:0]         o_cal_day,
    output logic [4:0]         o_cal_hour,
    output logic [5:0]         o_cal_minute,
    output logic [5:0]         o_cal_second,
    output logic [2:0]         o_weekday
);
    import ecal_pkg::*;

    logic [31:0] r_secs;
    logic [15:0] r_days;
    logic [16:0] r_tod;
    logic [13:0] r_wq;
    logic [2:0]  r_wd;
    logic [4:0]  r_hour;
    logic [11:0] r_mrem;
    logic [5:0]  r_min;
    logic [5:0]  r_sec;
    logic [11:0] r_year;
    logic [1:0]  r_y4;
    logic [6:0]  r_y100;
    logic [8:0]  r_y400;
    logic [3:0]  r_mon;
    logic        r_ovalid;

    logic [50:0] day_prod;
    logic [24:0] day_back;
    logic [24:0] day_rem;
    logic [32:0] wk_prod;
    logic [16:0] wk_back;
    logic [16:0] wk_rem;
    logic [3:0]  wd_add;
    logic [2:0]  wd_off;
    logic [34:0] hour_prod;
    logic [16:0] hour_back;
    logic [16:0] hour_rem;
    logic [24:0] min_prod;
    logic [11:0] min_back;
    logic [11:0] min_rem;
    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;
    logic        year_done;
    logic        month_done;
    logic        out_free;
    logic        emit;

    // day number = (secs / 128) / 675
    assign day_prod = {26'd0, r_secs[31:7]} * {25'd0, DayMul};
    assign day_back = {9'd0, r_days} * {15'd0, DayUnit};
    assign day_rem  = r_secs[31:7] - day_back;

    // day number mod 7
    assign wk_prod = {17'd0, r_days} * {16'd0, WeekMul};
    assign wk_back = {r_wq, 3'd0} - {3'd0, r_wq};
    assign wk_rem  = {1'b0, r_days} - wk_back;
    // epoch day was a Thursday
    assign wd_add = {1'b0, wk_rem[2:0]} + 4'd4;
    assign wd_off = (wd_add >= 4'd7) ? 3'(wd_add - 4'd7) : wd_add[2:0];

    assign hour_prod = {18'd0, r_tod} * {17'd0, HourMul};
    assign hour_back = {12'd0, r_hour} * SecsPerHour;
    assign hour_rem  = r_tod - hour_back;

    assign min_prod = {13'd0, r_mrem} * {12'd0, MinMul};
    assign min_back = {6'd0, r_min} * SecsPerMin;
    assign min_rem  = r_mrem - min_back;

    assign leap       = (r_y4 == 2'd0) && ((r_y100 != 7'd0) || (r_y400 == 9'd0));
    assign ylen       = leap ? 9'd366 : 9'd365;
    assign mlen       = month_len(r_mon, leap);
    assign year_done  = (r_days < {7'd0, ylen});
    assign month_done = (r_mon == 4'd11) || (r_days < {11'd0, mlen});

    assign out_free = !r_ovalid || i_out_ready;
    assign emit     = (i_ctl.cw.op == OP_EMIT) && i_ctl.go;

    assign o_stat = '{loop_done: (i_ctl.cw.op == OP_MONTH) ? month_done : year_done,
                      out_free: out_free};

    always_ff @(posedge i_clk) begin
        case (i_ctl.cw.op)
            OP_LOAD: begin
                if (i_ctl.go) begin
                    r_secs <= i_seconds_count;
                end
            end
            OP_DAY_Q: begin
                r_days <= day_prod[DayShift +: 16];
            end
            OP_DAY_R: begin
                r_tod <= {day_rem[9:0], r_secs[6:0]};
                r_wq  <= wk_prod[WeekShift +: 14];
            end
            OP_HOUR_Q: begin
                r_hour <= hour_prod[HourShift +: 5];
                r_wd   <= wd_off;
            end
            OP_HOUR_R: begin
                r_mrem <= hour_rem[11:0];
            end
            OP_MIN_Q: begin
                r_min <= min_prod[MinShift +: 6];
            end
            OP_MIN_R: begin
                r_sec  <= min_rem[5:0];
                r_year <= BaseYear;
                r_y4   <= BaseMod4;
                r_y100 <= BaseMod100;
                r_y400 <= BaseMod400;
                r_mon  <= '0;
            end
            OP_YEAR: begin
                if (!year_done) begin
                    r_days <= r_days - {7'd0, ylen};
                    r_year <= r_year + 12'd1;
                    r_y4   <= r_y4 + 2'd1;
                    r_y100 <= (r_y100 == 7'd99) ? 7'd0 : r_y100 + 7'd1;
                    r_y400 <= (r_y400 == 9'd399) ? 9'd0 : r_y400 + 9'd1;
                end
            end
            OP_MONTH: begin
                if (!month_done) begin
                    r_days <= r_days - {11'd0, mlen};
                    r_mon  <= r_mon + 4'd1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_cal_year   <= r_year;
            o_cal_month  <= r_mon + 4'd1;
            o_cal_day    <= r_days[4:0] + 5'd1;
            o_cal_hour   <= r_hour;
            o_cal_minute <= r_min;
            o_cal_second <= r_sec;
            o_weekday    <= r_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_out_valid = r_ovalid;

endmodule

FILE: rtl/core/epoch_seconds_to_calendar.sv
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 to Gregorian
// year, month, day, hour, minute, second and weekday (0 = Sunday), using the
// full leap rule. A small microcode program steps one shared datapath: six
// steps split the count into day number, hour, minute and second with
// reciprocal multiplies, then whole years are taken off one per cycle and whole
// months one per cycle. One item at a time is in work: the program takes an
// item at its wait step, runs the six split steps, the year loop, the month
// loop and the emit step, and only then returns to wait for the next item.
// The result sits in an output register, so the next item is taken while it
// waits; that item then holds at its last step until the output register is
// free.
module epoch_seconds_to_calendar (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ecal_in_if.sink        i_in,
    ecal_out_if.source     o_out
);
    import ecal_pkg::*;

    t_ctl       ctl;
    t_dp_stat   stat;
    logic       in_ready;
    logic       out_valid;
    logic [11:0] cal_year;
    logic [3:0]  cal_month;
    logic [4:0]  cal_day;
    logic [4:0]  cal_hour;
    logic [5:0]  cal_minute;
    logic [5:0]  cal_second;
    logic [2:0]  weekday;

    ecal_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_ctl      (ctl)
    );

    ecal_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .i_seconds_count (i_in.seconds_count),
        .i_out_ready     (o_out.ready),
        .o_stat          (stat),
        .o_out_valid     (out_valid),
        .o_cal_year      (cal_year),
        .o_cal_month     (cal_month),
        .o_cal_day       (cal_day),
        .o_cal_hour      (cal_hour),
        .o_cal_minute    (cal_minute),
        .o_cal_second    (cal_second),
        .o_weekday       (weekday)
    );

    assign i_in.ready       = in_ready;
    assign o_out.valid      = out_valid;
    assign o_out.cal_year   = cal_year;
    assign o_out.cal_month  = cal_month;
    assign o_out.cal_day    = cal_day;
    assign o_out.cal_hour   = cal_hour;
    assign o_out.cal_minute = cal_minute;
    assign o_out.cal_second = cal_second;
    assign o_out.weekday    = weekday;

endmodule

FILE: rtl/core/ecal_chk.sv
`include "epoch_seconds_to_calendar_assert.svh"

module ecal_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [11:0] i_cal_year,
    input logic [3:0]  i_cal_month,
    input logic [4:0]  i_cal_day,
    input logic [4:0]  i_cal_hour,
    input logic [5:0]  i_cal_minute,
    input logic [5:0]  i_cal_second,
    input logic [2:0]  i_weekday
);

    // ready drops once an item is taken
    `ECAL_ASSERT_NXT(a_busy_after_in, i_in_valid && i_in_ready, !i_in_ready)

    `ECAL_ASSERT_IMP(a_date_range, i_out_valid,
        i_cal_year >= 12'd1970 && i_cal_year <= 12'd2106 &&
        i_cal_month >= 4'd1 && i_cal_month <= 4'd12 &&
        i_cal_day >= 5'd1 && i_cal_day <= 5'd31 && i_weekday <= 3'd6)

    `ECAL_ASSERT_IMP(a_time_range, i_out_valid,
        i_cal_hour <= 5'd23 && i_cal_minute <= 6'd59 && i_cal_second <= 6'd59)

    `ECAL_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_cal_year) && $stable(i_cal_month) &&
        $stable(i_cal_day) && $stable(i_cal_hour) && $stable(i_cal_minute) &&
        $stable(i_cal_second) && $stable(i_weekday))

endmodule

bind epoch_seconds_to_calendar ecal_chk u_ecal_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_cal_year   (o_out.cal_year),
    .i_cal_month  (o_out.cal_month),
    .i_cal_day    (o_out.cal_day),
    .i_cal_hour   (o_out.cal_hour),
    .i_cal_minute (o_out.cal_minute),
    .i_cal_second (o_out.cal_second),
    .i_weekday    (o_out.weekday)
);

FILE: tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_ITEMS = 1180;
    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE_WAIT  = 200;
    localparam int LONG_HOLD_AT = 40;
    localparam int LONG_HOLD    = 600;

    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned EPOCH_YEAR    = 1970;
    localparam int unsigned LAST_DAY      = 49710;
    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    localparam int NUM_EDGES = 24;
    localparam logic [31:0] EDGE_SECS [NUM_EDGES] = '{
        32'd0,          32'd1,          32'd59,         32'd60,
        32'd3599,       32'd3600,       32'd86399,      32'd86400,
        32'd5097599,    32'd5097600,    32'd63071999,   32'd63072000,
        32'd68169600,   32'd63158399,   32'd951782400,  32'd978307199,
        32'd2147483647, 32'd2147483648, 32'd4107542399, 32'd4107542400,
        32'd4291747199, 32'd4291747200, 32'hAAAAAAAA,   32'hFFFFFFFF
    };

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
    } t_cal_date;

    typedef struct {
        logic [31:0] secs;
        int          gap;
        bit          drain;
    } t_secs_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ecal_in_if  in_ch ();
    ecal_out_if out_ch ();

    epoch_seconds_to_calendar uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_secs_item secs_q [$];
    t_cal_date  date_expect_q [$];

    int secs_sent    = 0;
    int dates_seen   = 0;
    int send_idle    = 0;
    int recv_wait    = 0;
    int stuck_cycles = 0;
    int err_cnt      = 0;
    int year_lo      = 4095;
    int year_hi      = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic bit is_leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // 1970-01-01 fell on a Thursday, so the weekday follows the day count
    function automatic t_cal_date calendar_of(input logic [31:0] secs);
        t_cal_date   r;
        int unsigned days, tod, yr, mon, ylen, mlen;
        days = secs / SECS_PER_DAY;
        tod  = secs % SECS_PER_DAY;
        r.weekday = 3'((days + 4) % 7);
        yr = EPOCH_YEAR;
        ylen = is_leap_year(yr) ? 366 : 365;
        while (days >= ylen) begin
            days -= ylen;
            yr++;
            ylen = is_leap_year(yr) ? 366 : 365;
        end
        mon = 0;
        while (mon < 11) begin
            mlen = (mon == 1 && is_leap_year(yr)) ? 29 : MONTH_DAYS[mon];
            if (days < mlen) break;
            days -= mlen;
            mon++;
        end
        r.year   = 12'(yr);
        r.month  = 4'(mon + 1);
        r.day    = 5'(days + 1);
        r.hour   = 5'(tod / SECS_PER_HOUR);
        r.minute = 6'((tod % SECS_PER_HOUR) / 60);
        r.second = 6'(tod % 60);
        return r;
    endfunction

    task automatic compare_field(input string fld, input int unsigned want,
                                 input int unsigned seen);
        if (want != seen) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fld, want, seen);
            err_cnt++;
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        t_secs_item nxt;
        logic       in_fire;
        logic       out_fire;
        int         open_cnt;
        in_fire  = in_ch.valid && in_ch.ready;
        out_fire = out_ch.valid && out_ch.ready;
        if (!i_rst_n) begin
            in_ch.valid         <= 1'b0;
            in_ch.seconds_count <= '0;
            send_idle           <= 0;
        end else begin
            if (in_fire) begin
                date_expect_q.push_back(calendar_of(in_ch.seconds_count));
                secs_sent <= secs_sent + 1;
            end
            open_cnt = secs_sent + int'(in_fire) - dates_seen - int'(out_fire);
            if (in_ch.valid && !in_fire) begin
                // transfer still pending, hold
            end else if (secs_q.size() != 0 && send_idle >= secs_q[0].gap
                         && (!secs_q[0].drain || open_cnt == 0)) begin
                nxt = secs_q.pop_front();
                in_ch.valid         <= 1'b1;
                in_ch.seconds_count <= nxt.secs;
                send_idle           <= 0;
            end else begin
                in_ch.valid <= 1'b0;
                send_idle   <= send_idle + 1;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_cal_date got;
        t_cal_date want;
        int        hold;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            recv_wait    <= 0;
        end else begin
            hold = recv_wait;
            if (out_ch.valid && out_ch.ready) begin
                got = '{year: out_ch.cal_year, month: out_ch.cal_month, day: out_ch.cal_day,
                        hour: out_ch.cal_hour, minute: out_ch.cal_minute,
                        second: out_ch.cal_second, weekday: out_ch.weekday};
                if (date_expect_q.size() == 0) begin
                    $display("%0t: unexpected result %0d-%0d-%0d", $time,
                             got.year, got.month, got.day);
                    err_cnt++;
                end else begin
                    want = date_expect_q.pop_front();
                    compare_field("year",    want.year,    got.year);
                    compare_field("month",   want.month,   got.month);
                    compare_field("day",     want.day,     got.day);
                    compare_field("hour",    want.hour,    got.hour);
                    compare_field("minute",  want.minute,  got.minute);
                    compare_field("second",  want.second,  got.second);
                    compare_field("weekday", want.weekday, got.weekday);
                end
                if (int'(got.year) < year_lo) year_lo = int'(got.year);
                if (int'(got.year) > year_hi) year_hi = int'(got.year);
                dates_seen <= dates_seen + 1;
                if (dates_seen == LONG_HOLD_AT) begin
                    hold = LONG_HOLD;
                end else begin
                    case ((dates_seen / 150) % 3)
                        0:       hold = $urandom_range(0, 8);
                        1:       hold = 0;
                        default: hold = $urandom_range(0, 2);
                    endcase
                end
            end else if (hold != 0) begin
                hold--;
            end
            recv_wait    <= hold;
            out_ch.ready <= (hold == 0);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, stuck_cycles);
            $display("epoch_seconds_to_calendar test failed");
            $finish;
        end
    end

    initial begin
        t_secs_item      item;
        int unsigned     mode, yr, mon, days;
        longint unsigned stamp;
        i_rst_n = 1'b0;

        foreach (EDGE_SECS[k]) begin
            item.secs  = EDGE_SECS[k];
            item.gap   = $urandom_range(0, 2);
            item.drain = 1'b0;
            secs_q.push_back(item);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            mode = $urandom_range(0, 9);
            if (mode < 4) begin
                item.secs = $urandom();
            end else if (mode < 7) begin
                // around midnight of a random day
                days = $urandom_range(0, LAST_DAY - 1);
                item.secs = days * SECS_PER_DAY
                          + ($urandom_range(0, 1) ? 86399 : $urandom_range(0, 3));
            end else begin
                // around the start of a random month
                yr   = $urandom_range(EPOCH_YEAR, 2106);
                mon  = $urandom_range(0, 11);
                days = 0;
                for (int unsigned y = EPOCH_YEAR; y < yr; y++)
                    days += is_leap_year(y) ? 366 : 365;
                for (int unsigned m = 0; m < mon; m++)
                    days += (m == 1 && is_leap_year(yr)) ? 29 : MONTH_DAYS[m];
                stamp = longint'(days) * SECS_PER_DAY;
                if (stamp != 0 && $urandom_range(0, 1))
                    stamp = stamp - 1;
                else
                    stamp = stamp + $urandom_range(0, 7200);
                if (stamp > 64'hFFFF_FFFF)
                    stamp = 64'hFFFF_FFFF - $urandom_range(0, 86399);
                item.secs = 32'(stamp);
            end
            case ((i / 100) % 3)
                0:       item.gap = $urandom_range(0, 8);
                1:       item.gap = 0;
                default: item.gap = $urandom_range(0, 3);
            endcase
            item.drain = (i == 0 || i == 400 || i == 900);
            secs_q.push_back(item);
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (secs_sent != NUM_EDGES + RANDOM_ITEMS || dates_seen != secs_sent)
            @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);

        if (date_expect_q.size() != 0) begin
            $display("%0t: %0d predicted dates never came out", $time, date_expect_q.size());
            err_cnt++;
        end

        $display("Decoded %0d second counts into dates from year %0d to %0d.",
                 dates_seen, year_lo, year_hi);
        $display("Included both 32-bit ends, leap days, month and year edges, "
                 , "a long output stall and a full drain.");
        if (err_cnt == 0) begin
            $display("epoch_seconds_to_calendar test passed");
        end else begin
            $display("epoch_seconds_to_calendar test failed");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/ecal_pkg.sv
rtl/core/ecal_ifs.sv
rtl/core/ecal_seq.sv
rtl/core/ecal_dp.sv
rtl/core/epoch_seconds_to_calendar.sv
rtl/core/ecal_chk.sv
tb/sv/tb_top.sv
